// ----- rtl/quaternion_to_euler_angles_assert.svh -----
// Assertion macros shared by the quaternion to Euler angle block.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Implication checked in the same cycle.
`define QTE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/qte_pkg.sv -----
// Package with the types, constants and tables of the quaternion to Euler angle block.
`default_nettype none
package qte_pkg;

    // Widths of the intermediate terms.
    localparam int TERM_W   = 35;
    localparam int T2C_W    = 30;
    localparam int REM_W    = 57;
    localparam int SQRT_N   = 29;
    localparam int CORDIC_N = 20;
    localparam int ZERO_DLY = 28;
    localparam int LANE_LAT = 29;
    localparam int TERM_LAT = 5;
    localparam int LAT      = TERM_LAT + SQRT_N + LANE_LAT + 1;

    localparam int PITCH_MAX = 12868;
    localparam int ANGLE_MAX = 25736;
    localparam logic signed [23:0] PI_Q20 = 24'sd3294199;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_in_word;

    typedef struct packed {
        logic signed [14:0] pitch_angle;
        logic signed [15:0] roll_angle;
        logic signed [15:0] yaw_angle;
    } t_out_word;

    // The five terms, with the pitch term already clamped.
    typedef struct packed {
        logic signed [TERM_W-1:0] t0;
        logic signed [TERM_W-1:0] t1;
        logic signed [T2C_W-1:0]  t2c;
        logic signed [TERM_W-1:0] t3;
        logic signed [TERM_W-1:0] t4;
    } t_terms;

    // Arctangent of 2^-i in radians at scale 2^20, rounded to nearest.
    function automatic logic signed [23:0] atan_q20(input logic [4:0] idx);
        logic signed [23:0] v;
        case (idx)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/qte_terms.sv -----
// Product and term stages: forms the five attitude terms and the radicand of the pitch root.
`default_nettype none
module qte_terms (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire qte_pkg::t_in_word                  i_word,
    output qte_pkg::t_terms                         o_terms,
    output logic [qte_pkg::REM_W-1:0]               o_rem
);

    localparam int TW = qte_pkg::TERM_W;
    localparam logic signed [TW-1:0] ONE_Q28 = TW'(1) <<< 28;
    localparam logic signed [TW-1:0] NEG_ONE = -(TW'(1) <<< 28);

    logic signed [31:0] r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx, r_xx;
    logic signed [TW-1:0] r_t0, r_t1, r_t2, r_t3, r_t4;
    qte_pkg::t_terms r_clamp, r_sq_terms, r_rem_terms;
    logic [59:0] r_sq;
    logic [qte_pkg::REM_W-1:0] r_rem;
    logic signed [qte_pkg::T2C_W-1:0] n_t2c;
    logic signed [59:0] n_prod;

    // Stage one: the nine component products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yy <= i_word.quat_y * i_word.quat_y;
            r_zz <= i_word.quat_z * i_word.quat_z;
            r_xy <= i_word.quat_x * i_word.quat_y;
            r_wz <= i_word.quat_w * i_word.quat_z;
            r_xz <= i_word.quat_x * i_word.quat_z;
            r_wy <= i_word.quat_w * i_word.quat_y;
            r_yz <= i_word.quat_y * i_word.quat_z;
            r_wx <= i_word.quat_w * i_word.quat_x;
            r_xx <= i_word.quat_x * i_word.quat_x;
        end
    end

    // Stage two: the five terms at scale 2^28.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0 <= ONE_Q28 - ((TW'(r_yy) + TW'(r_zz)) <<< 1);
            r_t1 <= (TW'(r_xy) + TW'(r_wz)) <<< 1;
            r_t2 <= (TW'(r_wy) - TW'(r_xz)) <<< 1;
            r_t3 <= (TW'(r_yz) + TW'(r_wx)) <<< 1;
            r_t4 <= ONE_Q28 - ((TW'(r_xx) + TW'(r_yy)) <<< 1);
        end
    end

    // Stage three: the pitch term is clamped to plus or minus one.
    always_comb begin
        if (r_t2 > ONE_Q28) begin
            n_t2c = qte_pkg::T2C_W'(ONE_Q28);
        end else if (r_t2 < NEG_ONE) begin
            n_t2c = qte_pkg::T2C_W'(NEG_ONE);
        end else begin
            n_t2c = qte_pkg::T2C_W'(r_t2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_clamp.t0  <= r_t0;
            r_clamp.t1  <= r_t1;
            r_clamp.t2c <= n_t2c;
            r_clamp.t3  <= r_t3;
            r_clamp.t4  <= r_t4;
        end
    end

    // Stage four: square of the clamped pitch term.
    assign n_prod = r_clamp.t2c * r_clamp.t2c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq       <= n_prod;
            r_sq_terms <= r_clamp;
        end
    end

    // Stage five: radicand one minus the square, at scale 2^56.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem       <= (qte_pkg::REM_W'(1) << 56) - r_sq[qte_pkg::REM_W-1:0];
            r_rem_terms <= r_sq_terms;
        end
    end

    assign o_terms = r_rem_terms;
    assign o_rem   = r_rem;

endmodule
`default_nettype wire

// ----- rtl/qte_sqrt_cell.sv -----
// One digit cell of the pipelined square root: settles one bit of the root.
`default_nettype none
module qte_sqrt_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [4:0]                          i_bit,
    input  wire logic [qte_pkg::REM_W-1:0]           i_rem,
    input  wire logic [qte_pkg::SQRT_N-1:0]          i_root,
    output logic [qte_pkg::REM_W-1:0]                o_rem,
    output logic [qte_pkg::SQRT_N-1:0]               o_root
);

    logic [59:0] n_trial;
    logic [59:0] n_wide;
    logic [qte_pkg::REM_W-1:0] n_rem;
    logic [qte_pkg::SQRT_N-1:0] n_root;

    // Setting this bit raises the square by root*2^(k+1) + 2^(2k).
    always_comb begin
        n_trial = (60'(i_root) << (6'(i_bit) + 6'd1)) + (60'd1 << {i_bit, 1'b0});
        n_wide  = 60'(i_rem);
        if (n_wide >= n_trial) begin
            n_rem  = qte_pkg::REM_W'(n_wide - n_trial);
            n_root = i_root | (qte_pkg::SQRT_N'(1) << i_bit);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_root <= n_root;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qte_cordic_cell.sv -----
// One vectoring micro-rotation of the arctangent pipeline.
`default_nettype none
module qte_cordic_cell (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [4:0]         i_step,
    input  wire logic signed [63:0] i_x,
    input  wire logic signed [63:0] i_y,
    input  wire logic signed [23:0] i_z,
    output logic signed [63:0]      o_x,
    output logic signed [63:0]      o_y,
    output logic signed [23:0]      o_z
);

    logic signed [63:0] n_xs, n_ys;
    logic signed [23:0] n_ang;

    assign n_xs  = i_x >>> i_step;
    assign n_ys  = i_y >>> i_step;
    assign n_ang = qte_pkg::atan_q20(i_step);

    // Rotate towards the x axis, steering by the sign of y.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[63]) begin
                o_x <= i_x + n_ys;
                o_y <= i_y - n_xs;
                o_z <= i_z + n_ang;
            end else begin
                o_x <= i_x - n_ys;
                o_y <= i_y + n_xs;
                o_z <= i_z - n_ang;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/qte_atan2.sv -----
// Full-quadrant arctangent lane: normalising shifts, quadrant fold and a chain of rotation cells.
`default_nettype none
module qte_atan2 (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [qte_pkg::TERM_W-1:0] i_y,
    input  wire logic signed [qte_pkg::TERM_W-1:0] i_x,
    output logic signed [16:0]                     o_ang
);

    localparam int TW = qte_pkg::TERM_W;
    localparam int NS = 6;

    logic [TW-1:0] n_ax, n_ay;
    logic signed [60:0] r_nx [NS+1];
    logic signed [60:0] r_ny [NS+1];
    logic [58:0] r_m [NS+1];
    logic r_zero [qte_pkg::ZERO_DLY];
    logic signed [63:0] r_fx, r_fy;
    logic signed [23:0] r_fz;
    logic signed [63:0] w_x [qte_pkg::CORDIC_N+1];
    logic signed [63:0] w_y [qte_pkg::CORDIC_N+1];
    logic signed [23:0] w_z [qte_pkg::CORDIC_N+1];
    logic signed [23:0] n_round;

    // Entry stage: magnitudes, the larger one and the zero over zero flag.
    assign n_ax = i_x[TW-1] ? TW'(-i_x) : TW'(i_x);
    assign n_ay = i_y[TW-1] ? TW'(-i_y) : TW'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nx[0]   <= 61'(i_x);
            r_ny[0]   <= 61'(i_y);
            r_m[0]    <= (n_ax > n_ay) ? 59'(n_ax) : 59'(n_ay);
            r_zero[0] <= (i_x == '0) && (i_y == '0);
        end
    end

    // Normalising shifts by 32, 16, 8, 4, 2 and 1 bring the larger
    // magnitude into [2^58, 2^59).
    for (genvar j = 0; j < NS; j++) begin : g_norm
        localparam int K = 32 >> j;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_m[j] < (59'(1) << (59 - K))) begin
                    r_m[j+1]  <= r_m[j] << K;
                    r_nx[j+1] <= r_nx[j] <<< K;
                    r_ny[j+1] <= r_ny[j] <<< K;
                end else begin
                    r_m[j+1]  <= r_m[j];
                    r_nx[j+1] <= r_nx[j];
                    r_ny[j+1] <= r_ny[j];
                end
            end
        end
    end

    // Quadrant fold: a negative x is mirrored and the angle starts at plus or minus pi.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_nx[NS][60]) begin
                r_fx <= -64'(r_nx[NS]);
                r_fy <= -64'(r_ny[NS]);
                r_fz <= r_ny[NS][60] ? -qte_pkg::PI_Q20 : qte_pkg::PI_Q20;
            end else begin
                r_fx <= 64'(r_nx[NS]);
                r_fy <= 64'(r_ny[NS]);
                r_fz <= 24'sd0;
            end
        end
    end

    assign w_x[0] = r_fx;
    assign w_y[0] = r_fy;
    assign w_z[0] = r_fz;

    // The rotation cells, one per iteration.
    for (genvar i = 0; i < qte_pkg::CORDIC_N; i++) begin : g_cell
        qte_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_step (5'(i)),
            .i_x    (w_x[i]),
            .i_y    (w_y[i]),
            .i_z    (w_z[i]),
            .o_x    (w_x[i+1]),
            .o_y    (w_y[i+1]),
            .o_z    (w_z[i+1])
        );
    end

    // The zero flag travels beside the data.
    for (genvar d = 1; d < qte_pkg::ZERO_DLY; d++) begin : g_zero
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[d] <= r_zero[d-1];
            end
        end
    end

    // Round half up from scale 2^20 to scale 2^13.
    assign n_round = (w_z[qte_pkg::CORDIC_N] + 24'sd64) >>> 7;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ang <= r_zero[qte_pkg::ZERO_DLY-1] ? 17'sd0 : 17'(n_round);
        end
    end

endmodule
`default_nettype wire

// ----- rtl/quaternion_to_euler_angles.sv -----
// Top level of the quaternion to Euler angle converter (Z-Y-X order).
//
// Input channel: i_in_valid / o_in_ready with i_in_word carrying the four
// Q2.14 quaternion components. Output channel: o_out_valid / i_out_ready with
// o_out_word carrying pitch, roll and yaw in radians, Q2.13 for pitch and Q3.13 for roll and yaw.
// A word is taken whenever valid and ready are both high on a clock edge.
// The path is a fixed pipeline of 64 register stages: five for the products
// and terms, 29 digit cells of the pitch square root, 29 for each arctangent
// lane (an entry stage, six normalising shifts, a quadrant fold, 20 rotation
// cells and a rounding stage) and one output register. One word is accepted
// every cycle while the receiver does not stall; the depth is set by the
// square root and rotation cell chains.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and o_in_ready falls; empty stages are not squeezed out during a stall.
// Reset (synchronous, active low) clears every stage's valid flag; payload
// registers keep whatever they held.
`default_nettype none
module quaternion_to_euler_angles (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire qte_pkg::t_in_word   i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output qte_pkg::t_out_word       o_out_word
);

    `include "quaternion_to_euler_angles_assert.svh"

    localparam int LAT = qte_pkg::LAT;
    localparam int SN  = qte_pkg::SQRT_N;

    logic w_en;
    logic [LAT-1:0] r_vld;
    qte_pkg::t_terms w_terms;
    logic [qte_pkg::REM_W-1:0] w_rem [SN+1];
    logic [SN-1:0] w_root [SN+1];
    qte_pkg::t_terms r_dly [SN];
    logic signed [16:0] w_pitch, w_roll, w_yaw;
    qte_pkg::t_out_word r_out;
    qte_pkg::t_out_word n_out;

    // The pipeline advances unless a finished word is held back.
    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_out_valid = r_vld[LAT-1];
    assign o_out_word  = r_out;

    // Valid flag of every stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    qte_terms u_terms (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_word  (i_in_word),
        .o_terms (w_terms),
        .o_rem   (w_rem[0])
    );

    // Square root of the radicand, most significant bit first.
    assign w_root[0] = '0;

    for (genvar j = 0; j < SN; j++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_bit  (5'(SN - 1 - j)),
            .i_rem  (w_rem[j]),
            .i_root (w_root[j]),
            .o_rem  (w_rem[j+1]),
            .o_root (w_root[j+1])
        );
    end

    // The terms wait beside the square root.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0] <= w_terms;
        end
    end

    for (genvar d = 1; d < SN; d++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dly[d] <= r_dly[d-1];
            end
        end
    end

    // Three arctangent lanes.
    qte_atan2 u_pitch (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (qte_pkg::TERM_W'(r_dly[SN-1].t2c)),
        .i_x   (qte_pkg::TERM_W'(w_root[SN])),
        .o_ang (w_pitch)
    );

    qte_atan2 u_roll (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_dly[SN-1].t3),
        .i_x   (r_dly[SN-1].t4),
        .o_ang (w_roll)
    );

    qte_atan2 u_yaw (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_dly[SN-1].t1),
        .i_x   (r_dly[SN-1].t0),
        .o_ang (w_yaw)
    );

    // Saturation to the output ranges.
    always_comb begin
        if (w_pitch > 17'(qte_pkg::PITCH_MAX)) begin
            n_out.pitch_angle = 15'(qte_pkg::PITCH_MAX);
        end else if (w_pitch < -17'(qte_pkg::PITCH_MAX)) begin
            n_out.pitch_angle = -15'(qte_pkg::PITCH_MAX);
        end else begin
            n_out.pitch_angle = 15'(w_pitch);
        end
        if (w_roll > 17'(qte_pkg::ANGLE_MAX)) begin
            n_out.roll_angle = 16'(qte_pkg::ANGLE_MAX);
        end else if (w_roll < -17'(qte_pkg::ANGLE_MAX)) begin
            n_out.roll_angle = -16'(qte_pkg::ANGLE_MAX);
        end else begin
            n_out.roll_angle = 16'(w_roll);
        end
        if (w_yaw > 17'(qte_pkg::ANGLE_MAX)) begin
            n_out.yaw_angle = 16'(qte_pkg::ANGLE_MAX);
        end else if (w_yaw < -17'(qte_pkg::ANGLE_MAX)) begin
            n_out.yaw_angle = -16'(qte_pkg::ANGLE_MAX);
        end else begin
            n_out.yaw_angle = 16'(w_yaw);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    // Results stay within the saturated ranges.
    `QTE_ASSERT_SAME(a_out_range, o_out_valid,
        (o_out_word.pitch_angle <= 15'sd12868) && (o_out_word.pitch_angle >= -15'sd12868) &&
        (o_out_word.roll_angle <= 16'sd25736) && (o_out_word.roll_angle >= -16'sd25736) &&
        (o_out_word.yaw_angle <= 16'sd25736) && (o_out_word.yaw_angle >= -16'sd25736),
        "Angle outside its range")
    // A held pipeline loses and invents no word.
    `QTE_ASSERT_NEXT(a_hold_vld, !w_en, $stable(r_vld), "Valid flags moved during a stall")
    // A delivered word with an empty stage behind it leaves the output empty.
    `QTE_ASSERT_NEXT(a_drain, o_out_valid && i_out_ready && !r_vld[LAT-2], !o_out_valid,
        "Word repeated at the output")

endmodule
`default_nettype wire
